[sv/ogrc_pkg.sv]
// Shared types and constants for the occupancy grid ray caster.
`default_nettype none
package ogrc_pkg;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_POINT  = 2'd1,
        MODE_READ   = 2'd2,
        MODE_UNUSED = 2'd3
    } t_mode;

    localparam logic [1:0] CELL_UNKNOWN  = 2'd0;
    localparam logic [1:0] CELL_FREE     = 2'd1;
    localparam logic [1:0] CELL_OCCUPIED = 2'd2;

    // signed width of a map coordinate before the bounds check
    localparam int CW = 11;
    // quotient bits of the per-step rounding division (result never exceeds 129)
    localparam int QW = 9;

    typedef struct packed {
        logic load;
        logic mul_sq;
        logic sqrt_init;
        logic sqrt_step;
        logic mulk;
        logic div_init;
        logic div_step;
        logic clr_step;
        logic mark;
        logic sel_end;
        logic k_inc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic sqrt_done;
        logic k_more;
        logic div_done;
        logic on_map;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

[sv/ogrc_if.sv]
// Valid/ready channel interfaces for requests and read results.
`default_nettype none
interface ogrc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [11:0]        cell_index;

    modport source (output valid, mode, point_x, point_y, cell_index, input ready);
    modport sink   (input valid, mode, point_x, point_y, cell_index, output ready);
endinterface

interface ogrc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cell_state;
    logic [11:0] read_index;

    modport source (output valid, cell_state, read_index, input ready);
    modport sink   (input valid, cell_state, read_index, output ready);
endinterface
`default_nettype wire

[sv/occupancy_grid_ray_caster_unit.sv]
// Top level of the occupancy grid ray caster.
`default_nettype none
// Keeps a GRID_WIDTH x GRID_WIDTH map of 2-bit cells centered on the robot and
// handles one request at a time. After reset the map is swept to unknown, one
// cell per cycle, before the first request is taken; a clear request takes the
// same sweep. A point request computes the squared distance and the 16-step
// square root, then for each freed cell does one multiply step for both axes,
// two 9-step rounding dividers run side by side for the two axes and one memory
// write, and then marks the endpoint; up to about GRID_WIDTH/2*1.5 ray steps.
// A read passes through the registered memory port and is held in an output
// register until taken.
module occupancy_grid_ray_caster_unit #(
    parameter int GRID_WIDTH = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ogrc_in_if.sink    i_req,
    ogrc_out_if.source o_res
);
    import ogrc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ogrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_mode     (i_req.mode),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ogrc_datapath #(
        .GRID_WIDTH (GRID_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_point_x    (i_req.point_x),
        .i_point_y    (i_req.point_y),
        .i_cell_index (i_req.cell_index),
        .i_out_ready  (o_res.ready),
        .o_out_valid  (o_res.valid),
        .o_cell_state (o_res.cell_state),
        .o_read_index (o_res.read_index)
    );

`ifndef SYNTHESIS
    a_busy_after_txn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.mode != MODE_UNUSED) |=> !i_req.ready)
        else $error("request accepted on consecutive cycles");
    a_sweep_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_req.ready)
        else $error("request taken during clearing sweep");
    a_cell_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.cell_state == CELL_UNKNOWN || o_res.cell_state == CELL_FREE
                         || o_res.cell_state == CELL_OCCUPIED))
        else $error("invalid cell state on result");
`endif

endmodule
`default_nettype wire

[sv/ogrc_datapath.sv]
// Datapath: grid memory, square root, rounding dividers, address math, result register.
`default_nettype none
module ogrc_datapath #(
    parameter int GRID_WIDTH = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire ogrc_pkg::t_cmd i_cmd,
    output ogrc_pkg::t_sts      o_sts,
    input  wire signed [15:0]   i_point_x,
    input  wire signed [15:0]   i_point_y,
    input  wire [11:0]          i_cell_index,
    input  wire                 i_out_ready,
    output logic                o_out_valid,
    output logic [1:0]          o_cell_state,
    output logic [11:0]         o_read_index
);
    import ogrc_pkg::*;

    localparam int CELLS = GRID_WIDTH * GRID_WIDTH;
    localparam int AW    = $clog2(CELLS);
    localparam int HALF  = GRID_WIDTH / 2;

    logic [1:0] mem [CELLS];

    logic [15:0] r_ax, r_ay;
    logic        r_nx, r_ny;
    logic [11:0] r_idx;
    logic [31:0] r_sqx, r_sqy;
    logic [31:0] r_rem, r_res, r_bit;
    logic [7:0]  r_k;
    logic [23:0] r_mx, r_my;
    logic [24:0] r_remx, r_remy, r_dsh;
    logic [QW-1:0] r_qx, r_qy;
    logic [3:0]  r_dc;
    logic [AW-1:0] r_clr;
    logic [1:0]  r_rdata;
    logic        r_out_valid;
    logic [1:0]  r_cell;
    logic [11:0] r_ridx;

    logic [15:0]        ray_len;
    logic [31:0]        sq_try;
    logic [QW-1:0]      ex, ey, selx, sely;
    logic signed [CW-1:0] cx, cy;
    logic               in_x, in_y;
    logic [AW-1:0]      waddr, raddr;
    logic               we;
    logic [1:0]         wdata;
    logic               oob;

    assign ray_len = r_res[15:0];
    assign sq_try  = r_res + r_bit;
    assign ex      = QW'((17'(r_ax) + 17'd128) >> 8);
    assign ey      = QW'((17'(r_ay) + 17'd128) >> 8);
    assign selx    = i_cmd.sel_end ? ex : r_qx;
    assign sely    = i_cmd.sel_end ? ey : r_qy;

    always_comb begin
        cx = r_nx ? -$signed(CW'(selx)) : $signed(CW'(selx));
        cy = r_ny ? -$signed(CW'(sely)) : $signed(CW'(sely));
        cx = cx + CW'(HALF);
        cy = cy + CW'(HALF);
    end

    assign in_x  = (cx >= 0) && (cx < CW'(GRID_WIDTH));
    assign in_y  = (cy >= 0) && (cy < CW'(GRID_WIDTH));
    assign waddr = i_cmd.clr_step ? r_clr
                 : AW'(32'(cx[7:0]) + 32'(cy[7:0]) * 32'(GRID_WIDTH));
    assign wdata = i_cmd.clr_step ? CELL_UNKNOWN
                 : (i_cmd.sel_end ? CELL_OCCUPIED : CELL_FREE);
    assign we    = i_cmd.clr_step || (i_cmd.mark && in_x && in_y);
    assign raddr = AW'(r_idx);
    assign oob   = 32'(r_idx) >= 32'(CELLS);

    assign o_sts.clr_last  = (r_clr == AW'(CELLS - 1));
    assign o_sts.sqrt_done = (r_bit == 32'd0);
    assign o_sts.k_more    = ({r_k, 8'h00} < ray_len);
    assign o_sts.div_done  = (r_dc == 4'd0);
    assign o_sts.on_map    = in_x && in_y;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    // payload and arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax  <= i_point_x[15] ? 16'(-i_point_x) : 16'(i_point_x);
            r_ay  <= i_point_y[15] ? 16'(-i_point_y) : 16'(i_point_y);
            r_nx  <= i_point_x[15];
            r_ny  <= i_point_y[15];
            r_idx <= i_cell_index;
        end
        if (i_cmd.mul_sq) begin
            r_sqx <= r_ax * r_ax;
            r_sqy <= r_ay * r_ay;
        end
        if (i_cmd.sqrt_init) begin
            r_rem <= r_sqx + r_sqy;
            r_res <= 32'd0;
            r_bit <= 32'h4000_0000;
            r_k   <= 8'd0;
        end else begin
            if (i_cmd.sqrt_step) begin
                if (r_rem >= sq_try) begin
                    r_rem <= r_rem - sq_try;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            if (i_cmd.k_inc) begin
                r_k <= r_k + 8'd1;
            end
        end
        if (i_cmd.mulk) begin
            r_mx <= r_k * r_ax;
            r_my <= r_k * r_ay;
        end
        // round half away from zero: (2*mag + d) / (2*d)
        if (i_cmd.div_init) begin
            r_remx <= {r_mx, 1'b0} + 25'(ray_len);
            r_remy <= {r_my, 1'b0} + 25'(ray_len);
            r_dsh  <= 25'({ray_len, 1'b0}) << (QW - 1);
            r_qx   <= '0;
            r_qy   <= '0;
            r_dc   <= 4'(QW);
        end else if (i_cmd.div_step) begin
            if (r_remx >= r_dsh) begin
                r_remx <= r_remx - r_dsh;
                r_qx   <= {r_qx[QW-2:0], 1'b1};
            end else begin
                r_qx   <= {r_qx[QW-2:0], 1'b0};
            end
            if (r_remy >= r_dsh) begin
                r_remy <= r_remy - r_dsh;
                r_qy   <= {r_qy[QW-2:0], 1'b1};
            end else begin
                r_qy   <= {r_qy[QW-2:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
            r_dc  <= r_dc - 4'd1;
        end
        if (i_cmd.out_load) begin
            r_cell <= oob ? CELL_UNKNOWN : r_rdata;
            r_ridx <= r_idx;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + AW'(1);
            end else if (i_cmd.load) begin
                r_clr <= '0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_state = r_cell;
    assign o_read_index = r_ridx;

endmodule
`default_nettype wire

[sv/ogrc_ctrl.sv]
// Controller: sequences clearing, ray casting and cell reads.
`default_nettype none
module ogrc_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire [1:0]           i_mode,
    output logic                o_in_ready,
    input  wire ogrc_pkg::t_sts i_sts,
    output ogrc_pkg::t_cmd      o_cmd
);
    import ogrc_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CLR, S_MUL, S_SQI, S_SQ, S_KCHK,
        S_DIVI, S_DIV, S_MARK, S_END, S_RDA, S_RDO
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT, S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    unique case (i_mode)
                        MODE_CLEAR: n_state = S_CLR;
                        MODE_POINT: n_state = S_MUL;
                        MODE_READ:  n_state = S_RDA;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.mul_sq = 1'b1;
                n_state = S_SQI;
            end
            S_SQI: begin
                o_cmd.sqrt_init = 1'b1;
                n_state = S_SQ;
            end
            S_SQ: begin
                if (i_sts.sqrt_done) n_state = S_KCHK;
                else o_cmd.sqrt_step = 1'b1;
            end
            S_KCHK: begin
                if (i_sts.k_more) begin
                    o_cmd.mulk = 1'b1;
                    n_state = S_DIVI;
                end else begin
                    n_state = S_END;
                end
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_MARK;
                else o_cmd.div_step = 1'b1;
            end
            S_MARK: begin
                // first cell off the map ends the walk
                if (i_sts.on_map) begin
                    o_cmd.mark  = 1'b1;
                    o_cmd.k_inc = 1'b1;
                    n_state = S_KCHK;
                end else begin
                    n_state = S_END;
                end
            end
            S_END: begin
                o_cmd.mark    = 1'b1;
                o_cmd.sel_end = 1'b1;
                n_state = S_IDLE;
            end
            S_RDA: n_state = S_RDO;
            S_RDO: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire
